[rtl/spt_pkg.sv]
// Shared types, register indexes and reset values for the sync pulse train generator.
`timescale 1ns / 1ps

package spt_pkg;

	localparam int TICK_COUNT_WIDTH_DEF   = 24;
	localparam int PULSE_NUMBER_WIDTH_DEF = 5;
	localparam int PULSE_COUNT_W          = 5;
	localparam int CFG_INDEX_W            = 3;

	localparam int SYNC_HIGH_RST        = 50;
	localparam int FIRST_HIGH_RST       = 400;
	localparam int HIGH_STEP_RST        = 50;
	localparam int GAP_RST              = 900;
	localparam int FINAL_GAP_RST        = 6000;
	localparam int PULSES_PER_FRAME_RST = 16;
	localparam int PULSES_DROPPED_RST   = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SYNC_HIGH        = 3'd0,
		CFG_FIRST_HIGH       = 3'd1,
		CFG_HIGH_STEP        = 3'd2,
		CFG_GAP              = 3'd3,
		CFG_FINAL_GAP        = 3'd4,
		CFG_PULSES_PER_FRAME = 3'd5,
		CFG_PULSES_DROPPED   = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_SYNC  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_GAP   = 2'd2,
		PH_FINAL = 2'd3
	} phase_t;

	typedef struct packed {
		logic enable;
		logic short_mode;
	} flags_t;

endpackage

[rtl/spt_cfg_regs.sv]
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module spt_cfg_regs #(
	parameter int TICK_COUNT_WIDTH = spt_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [spt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [TICK_COUNT_WIDTH-1:0]         cfg_data,
	output logic [TICK_COUNT_WIDTH-1:0]         sync_high_q,
	output logic [TICK_COUNT_WIDTH-1:0]         first_high_q,
	output logic [TICK_COUNT_WIDTH-1:0]         high_step_q,
	output logic [TICK_COUNT_WIDTH-1:0]         gap_q,
	output logic [TICK_COUNT_WIDTH-1:0]         final_gap_q,
	output logic [spt_pkg::PULSE_COUNT_W-1:0]   pulses_per_frame_q,
	output logic [spt_pkg::PULSE_COUNT_W-1:0]   pulses_dropped_q
);
	import spt_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_high_q        <= TW'(SYNC_HIGH_RST);
			first_high_q       <= TW'(FIRST_HIGH_RST);
			high_step_q        <= TW'(HIGH_STEP_RST);
			gap_q              <= TW'(GAP_RST);
			final_gap_q        <= TW'(FINAL_GAP_RST);
			pulses_per_frame_q <= PULSE_COUNT_W'(PULSES_PER_FRAME_RST);
			pulses_dropped_q   <= PULSE_COUNT_W'(PULSES_DROPPED_RST);
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SYNC_HIGH:        sync_high_q        <= cfg_data;
				CFG_FIRST_HIGH:       first_high_q       <= cfg_data;
				CFG_HIGH_STEP:        high_step_q        <= cfg_data;
				CFG_GAP:              gap_q              <= cfg_data;
				CFG_FINAL_GAP:        final_gap_q        <= cfg_data;
				CFG_PULSES_PER_FRAME: pulses_per_frame_q <= cfg_data[PULSE_COUNT_W-1:0];
				CFG_PULSES_DROPPED:   pulses_dropped_q   <= cfg_data[PULSE_COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/spt_btn_flags.sv]
// Button edge detection and the enable and short mode flags.
`timescale 1ns / 1ps

module spt_btn_flags (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            enable_button,
	input  logic            select_button,
	output spt_pkg::flags_t flags_next
);
	import spt_pkg::*;

	logic enable_flag_q;
	logic short_flag_q;
	logic enable_last_q;
	logic select_last_q;

	always_comb begin
		flags_next.enable     = enable_flag_q ^ (enable_button & ~enable_last_q);
		flags_next.short_mode = short_flag_q ^ (select_button & ~select_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_flag_q <= 1'b0;
			short_flag_q  <= 1'b1;
			enable_last_q <= 1'b0;
			select_last_q <= 1'b0;
		end else if (step) begin
			enable_flag_q <= flags_next.enable;
			short_flag_q  <= flags_next.short_mode;
			enable_last_q <= enable_button;
			select_last_q <= select_button;
		end
	end

endmodule

[rtl/spt_frame_seq.sv]
// Frame sequencer: phase, pulse number and tick counter, with zero length phase skipping.
`timescale 1ns / 1ps

module spt_frame_seq #(
	parameter int TICK_COUNT_WIDTH   = spt_pkg::TICK_COUNT_WIDTH_DEF,
	parameter int PULSE_NUMBER_WIDTH = spt_pkg::PULSE_NUMBER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                short_mode,
	input  logic [TICK_COUNT_WIDTH-1:0]         sync_high,
	input  logic [TICK_COUNT_WIDTH-1:0]         first_high,
	input  logic [TICK_COUNT_WIDTH-1:0]         high_step,
	input  logic [TICK_COUNT_WIDTH-1:0]         gap,
	input  logic [TICK_COUNT_WIDTH-1:0]         final_gap,
	input  logic [spt_pkg::PULSE_COUNT_W-1:0]   pulses_per_frame,
	input  logic [spt_pkg::PULSE_COUNT_W-1:0]   pulses_dropped,
	output spt_pkg::phase_t                     phase
);
	import spt_pkg::*;

	localparam int TW     = TICK_COUNT_WIDTH;
	localparam int PW     = PULSE_NUMBER_WIDTH;
	localparam int PROD_W = TW + PW;
	localparam int CMP_W  = (PW + 1 > PULSE_COUNT_W) ? PW + 1 : PULSE_COUNT_W;

	typedef struct packed {
		logic          found;
		phase_t        phase;
		logic [PW-1:0] pn;
		logic [TW-1:0] ticks;
	} search_t;

	phase_t        phase_q;
	logic [PW-1:0] pn_q;
	logic [TW-1:0] ticks_q;

	logic [PULSE_COUNT_W-1:0] train_len;
	logic                     two_ok;
	logic [PW-1:0]            pn_sel;
	logic [PW:0]              k_a;
	logic                     exists_a;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W:0]          width_sum;
	logic [TW-1:0]            w_a;
	search_t                  res_a;
	search_t                  res_b;
	search_t                  nxt;
	logic                     use_a;

	// Looks for the first nonzero phase starting at the high phase of pulse k.
	// Widths never shrink along the train, so a zero width beyond the first pulse
	// means every later pulse is zero as well.
	function automatic search_t pulse_search(input logic exists_k, input logic [PW-1:0] k,
			input logic k_one, input logic [TW-1:0] wk, input logic [TW-1:0] gap_len,
			input logic [TW-1:0] step_len, input logic second_ok);
		search_t r;
		r.found = 1'b1;
		r.phase = PH_HIGH;
		r.pn    = k;
		r.ticks = wk;
		if (exists_k && wk != '0) begin
			r.phase = PH_HIGH;
		end else if (exists_k && gap_len != '0) begin
			r.phase = PH_GAP;
			r.ticks = gap_len;
		end else if (exists_k && k_one && step_len != '0 && second_ok) begin
			r.pn    = PW'(2);
			r.ticks = step_len;
		end else begin
			r.found = 1'b0;
		end
		return r;
	endfunction

	assign phase = phase_q;

	always_comb begin
		if (short_mode) begin
			train_len = (pulses_per_frame > pulses_dropped) ?
				PULSE_COUNT_W'(pulses_per_frame - pulses_dropped) : '0;
		end else begin
			train_len = pulses_per_frame;
		end
		two_ok = train_len >= PULSE_COUNT_W'(2);

		// Pulse k uses a high time of first + (k - 1) * step, saturated.
		pn_sel    = (phase_q == PH_SYNC) ? '0 : pn_q;
		k_a       = {1'b0, pn_sel} + (PW + 1)'(1);
		exists_a  = !k_a[PW] && (CMP_W'(k_a) <= CMP_W'(train_len));
		prod      = PROD_W'(pn_sel) * PROD_W'(high_step);
		width_sum = {1'b0, prod} + (PROD_W + 1)'(first_high);
		w_a       = (|width_sum[PROD_W:TW]) ? '1 : width_sum[TW-1:0];

		res_a = pulse_search(exists_a, k_a[PW-1:0], k_a == (PW + 1)'(1), w_a, gap,
			high_step, two_ok);
		res_b = pulse_search(train_len != '0, PW'(1), 1'b1, first_high, gap, high_step,
			two_ok);

		use_a     = 1'b1;
		nxt.found = 1'b1;
		nxt.phase = PH_GAP;
		nxt.pn    = pn_q;
		nxt.ticks = gap;
		unique case (phase_q)
			PH_HIGH:  use_a = (gap == '0);
			PH_SYNC:  use_a = 1'b1;
			PH_GAP:   use_a = 1'b1;
			PH_FINAL: use_a = 1'b0;
			default:  use_a = 1'b0;
		endcase

		if (phase_q == PH_HIGH && gap != '0) begin
			nxt.phase = PH_GAP;
		end else if (use_a && res_a.found) begin
			nxt = res_a;
		end else if (phase_q != PH_FINAL && final_gap != '0) begin
			nxt.phase = PH_FINAL;
			nxt.ticks = final_gap;
		end else if (sync_high != '0) begin
			nxt.phase = PH_SYNC;
			nxt.pn    = PW'(1);
			nxt.ticks = sync_high;
		end else if (res_b.found) begin
			nxt = res_b;
		end else if (final_gap != '0) begin
			nxt.phase = PH_FINAL;
			nxt.ticks = final_gap;
		end else begin
			// Every phase of the frame is empty: rest in sync with no ticks loaded.
			nxt.phase = PH_SYNC;
			nxt.pn    = PW'(1);
			nxt.ticks = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			pn_q    <= PW'(1);
			ticks_q <= TW'(SYNC_HIGH_RST);
		end else if (step) begin
			if (ticks_q <= TW'(1)) begin
				phase_q <= nxt.phase;
				pn_q    <= nxt.pn;
				ticks_q <= nxt.ticks;
			end else begin
				ticks_q <= ticks_q - TW'(1);
			end
		end
	end

endmodule

[rtl/sync_pulse_train_generator.sv]
// Top level of the sync pulse train generator: input stage, sequencer and result register.
//
// One item arrives per timer tick on the item channel (item_valid / item_ready) and
// carries the two button levels. Each item produces exactly one result on the result
// channel (result_valid / result_ready): the data and sync line levels for that tick
// and the enable and short mode flags after the tick's button update.
// The item is captured in an input register, then the flags and frame sequencer step once
// and the levels are captured in the result register.
// Throughput is one item per cycle while the receiver does not stall; the sequencer's
// next phase logic, including one pulse width multiply, is the path that sets it.
// When the receiver stalls, the result register holds, the input register keeps one
// more item, and then item_ready drops until the result is taken.
// Reset clears both channels, loads the default registers and starts in the sync phase
// with the enable flag off and short mode on.
// Configuration writes on cfg_write_en take effect at the next phase load; the user must
// make them while no items are in flight, as the block does not enforce this itself.
`timescale 1ns / 1ps

module sync_pulse_train_generator #(
	parameter int TICK_COUNT_WIDTH   = spt_pkg::TICK_COUNT_WIDTH_DEF,
	parameter int PULSE_NUMBER_WIDTH = spt_pkg::PULSE_NUMBER_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [spt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [TICK_COUNT_WIDTH-1:0]     cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            enable_button,
	input  logic                            select_button,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic                            data_level,
	output logic                            sync_level,
	output logic                            enabled_now,
	output logic                            short_mode_now
);
	import spt_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;

	logic [TW-1:0]            sync_high;
	logic [TW-1:0]            first_high;
	logic [TW-1:0]            high_step;
	logic [TW-1:0]            gap;
	logic [TW-1:0]            final_gap;
	logic [PULSE_COUNT_W-1:0] pulses_per_frame;
	logic [PULSE_COUNT_W-1:0] pulses_dropped;

	logic   valid_s1;
	logic   enable_button_s1;
	logic   select_button_s1;
	logic   advance;
	logic   step;
	flags_t flags_next;
	phase_t phase;

	logic result_valid_q;
	logic data_level_q;
	logic sync_level_q;
	logic enabled_now_q;
	logic short_mode_now_q;

	assign advance    = !result_valid_q || result_ready;
	assign step       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			enable_button_s1 <= enable_button;
			select_button_s1 <= select_button;
		end
	end

	spt_cfg_regs #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sync_high_q       (sync_high),
		.first_high_q      (first_high),
		.high_step_q       (high_step),
		.gap_q             (gap),
		.final_gap_q       (final_gap),
		.pulses_per_frame_q(pulses_per_frame),
		.pulses_dropped_q  (pulses_dropped)
	);

	spt_btn_flags u_flags (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.enable_button(enable_button_s1),
		.select_button(select_button_s1),
		.flags_next   (flags_next)
	);

	spt_frame_seq #(
		.TICK_COUNT_WIDTH  (TICK_COUNT_WIDTH),
		.PULSE_NUMBER_WIDTH(PULSE_NUMBER_WIDTH)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.short_mode      (flags_next.short_mode),
		.sync_high       (sync_high),
		.first_high      (first_high),
		.high_step       (high_step),
		.gap             (gap),
		.final_gap       (final_gap),
		.pulses_per_frame(pulses_per_frame),
		.pulses_dropped  (pulses_dropped),
		.phase           (phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			data_level_q     <= (phase == PH_HIGH) && flags_next.enable;
			sync_level_q     <= (phase == PH_SYNC);
			enabled_now_q    <= flags_next.enable;
			short_mode_now_q <= flags_next.short_mode;
		end
	end

	assign result_valid   = result_valid_q;
	assign data_level     = data_level_q;
	assign sync_level     = sync_level_q;
	assign enabled_now    = enabled_now_q;
	assign short_mode_now = short_mode_now_q;

endmodule

[rtl/spt_port_checker.sv]
// Port level checks for the sync pulse train generator and their binding.
`timescale 1ns / 1ps

module spt_port_checker (
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic data_level,
	input logic sync_level,
	input logic enabled_now,
	input logic short_mode_now
);

	// A stalled result holds its value until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(data_level)
			&& $stable(sync_level) && $stable(enabled_now) && $stable(short_mode_now))
		else $error("stalled result changed");

	// The data line and the sync line are never high in the same tick.
	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(data_level && sync_level))
		else $error("data and sync high together");

	// The data line is gated by the enable flag of the same tick.
	a_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && data_level |-> enabled_now)
		else $error("data high while disabled");

	// Items are refused only while a finished result waits on a stalled receiver.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item refused without a stalled result");

endmodule

bind sync_pulse_train_generator spt_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_ready    (item_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.data_level    (data_level),
	.sync_level    (sync_level),
	.enabled_now   (enabled_now),
	.short_mode_now(short_mode_now)
);

[verif/spt_line_checker.sv]
// Checker that predicts the sync and data line levels of every tick and compares them.
`timescale 1ns / 1ps

module spt_line_checker
	import spt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TICK_COUNT_WIDTH_DEF-1:0] cfg_data,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  logic                   enable_button,
	input  logic                   select_button,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  logic                   data_level,
	input  logic                   sync_level,
	input  logic                   enabled_now,
	input  logic                   short_mode_now,
	output int                     outstanding,
	output int                     fail_count
);

	localparam int TW = TICK_COUNT_WIDTH_DEF;
	localparam longint unsigned TICK_MAX = (64'd1 << TW) - 64'd1;
	localparam int PULSE_NUM_MAX = (1 << PULSE_NUMBER_WIDTH_DEF) - 1;

	typedef struct packed {
		logic data;
		logic sync;
		logic enabled;
		logic short_mode;
	} line_levels_t;

	logic [TW-1:0] sync_high, first_high, high_step, gap_len, final_gap;
	logic [PULSE_COUNT_W-1:0] pulses_per_frame, pulses_dropped;

	phase_t phase;
	int pulse_num;
	logic [TW-1:0] ticks_left, cur_width;
	logic en_flag, short_flag, en_last, sel_last;

	line_levels_t expected_levels[$];
	int mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s got %b expected %b", name, got, want));
	endtask

	function automatic int train_length();
		if (short_flag)
			return (pulses_per_frame > pulses_dropped) ?
				int'(pulses_per_frame) - int'(pulses_dropped) : 0;
		return int'(pulses_per_frame);
	endfunction

	function automatic logic [TW-1:0] pulse_width(input int n);
		longint unsigned w;
		w = 64'(first_high) + 64'(n - 1) * 64'(high_step);
		return (w > TICK_MAX) ? '1 : w[TW-1:0];
	endfunction

	function automatic void start_pulse_or_final(input int n);
		if (n <= train_length() && n <= PULSE_NUM_MAX) begin
			pulse_num = n;
			cur_width = pulse_width(n);
			phase = PH_HIGH;
			ticks_left = cur_width;
		end else begin
			phase = PH_FINAL;
			ticks_left = final_gap;
		end
	endfunction

	// Zero length phases are passed over; an all-zero frame parks in the sync phase.
	function automatic void advance_phase();
		int sync_entries;
		logic done;
		sync_entries = 0;
		done = 1'b0;
		while (!done) begin
			case (phase)
				PH_SYNC: begin
					start_pulse_or_final(1);
				end
				PH_HIGH: begin
					phase = PH_GAP;
					ticks_left = gap_len;
				end
				PH_GAP: begin
					start_pulse_or_final(pulse_num + 1);
				end
				default: begin
					phase = PH_SYNC;
					pulse_num = 1;
					ticks_left = sync_high;
					sync_entries++;
				end
			endcase
			if (ticks_left != 0)
				done = 1'b1;
			else if (phase == PH_SYNC && sync_entries >= 2)
				done = 1'b1;
		end
	endfunction

	function automatic line_levels_t predict_levels(input logic eb, input logic sb);
		line_levels_t lv;
		if (eb && !en_last)
			en_flag = ~en_flag;
		if (sb && !sel_last)
			short_flag = ~short_flag;
		en_last = eb;
		sel_last = sb;
		lv.data = (phase == PH_HIGH) && en_flag;
		lv.sync = (phase == PH_SYNC);
		lv.enabled = en_flag;
		lv.short_mode = short_flag;
		if (ticks_left <= 1) begin
			ticks_left = '0;
			advance_phase();
		end else begin
			ticks_left--;
		end
		return lv;
	endfunction

	function automatic void apply_config(input cfg_index_t idx, input logic [TW-1:0] value);
		case (idx)
			CFG_SYNC_HIGH:        sync_high = value;
			CFG_FIRST_HIGH:       first_high = value;
			CFG_HIGH_STEP:        high_step = value;
			CFG_GAP:              gap_len = value;
			CFG_FINAL_GAP:        final_gap = value;
			CFG_PULSES_PER_FRAME: pulses_per_frame = value[PULSE_COUNT_W-1:0];
			CFG_PULSES_DROPPED:   pulses_dropped = value[PULSE_COUNT_W-1:0];
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_levels_t want;
		if (!arst_n) begin
			sync_high = TW'(SYNC_HIGH_RST);
			first_high = TW'(FIRST_HIGH_RST);
			high_step = TW'(HIGH_STEP_RST);
			gap_len = TW'(GAP_RST);
			final_gap = TW'(FINAL_GAP_RST);
			pulses_per_frame = PULSE_COUNT_W'(PULSES_PER_FRAME_RST);
			pulses_dropped = PULSE_COUNT_W'(PULSES_DROPPED_RST);
			phase = PH_SYNC;
			pulse_num = 1;
			ticks_left = TW'(SYNC_HIGH_RST);
			cur_width = TW'(FIRST_HIGH_RST);
			en_flag = 1'b0;
			short_flag = 1'b1;
			en_last = 1'b0;
			sel_last = 1'b0;
			expected_levels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write_en)
				apply_config(cfg_index_t'(cfg_index), cfg_data);
			if (item_valid && item_ready)
				expected_levels.push_back(predict_levels(enable_button, select_button));
			if (result_valid && result_ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("result arrived with no item outstanding");
				end else begin
					want = expected_levels.pop_front();
					check_field("data_level", data_level, want.data);
					check_field("sync_level", sync_level, want.sync);
					check_field("enabled_now", enabled_now, want.enabled);
					check_field("short_mode_now", short_mode_now, want.short_mode);
				end
			end
			outstanding <= expected_levels.size();
		end
	end

endmodule

[verif/sync_pulse_train_generator_tb.sv]
// Testbench top for the sync pulse train generator: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module sync_pulse_train_generator_tb;
	import spt_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH_DEF;
	localparam logic [TW-1:0] TICK_ALL_ONES = '1;
	localparam int PULSE_COUNT_MAX = (1 << PULSE_COUNT_W) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	cfg_index_t cfg_index = CFG_SYNC_HIGH;
	logic [TW-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic enable_button = 1'b0;
	logic select_button = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic data_level, sync_level, enabled_now, short_mode_now;

	int outstanding;
	int fail_count;
	logic idle_on = 1'b1;
	logic eb_level = 1'b0;
	logic sb_level = 1'b0;
	logic [TW-1:0] setting [1 << CFG_INDEX_W];
	logic [1:0] press_seq [12] = '{2'b00, 2'b10, 2'b10, 2'b00, 2'b01, 2'b01,
		2'b11, 2'b00, 2'b11, 2'b10, 2'b01, 2'b00};

	always #4 clk = ~clk;

	sync_pulse_train_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.enable_button (enable_button),
		.select_button (select_button),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.data_level    (data_level),
		.sync_level    (sync_level),
		.enabled_now   (enabled_now),
		.short_mode_now(short_mode_now)
	);

	spt_line_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.enable_button (enable_button),
		.select_button (select_button),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.data_level    (data_level),
		.sync_level    (sync_level),
		.enabled_now   (enabled_now),
		.short_mode_now(short_mode_now),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	function automatic void set_timing(input logic [TW-1:0] sync_high, first_high, high_step,
		gap_len, final_gap, input int pulses, dropped);
		setting[CFG_SYNC_HIGH] = sync_high;
		setting[CFG_FIRST_HIGH] = first_high;
		setting[CFG_HIGH_STEP] = high_step;
		setting[CFG_GAP] = gap_len;
		setting[CFG_FINAL_GAP] = final_gap;
		setting[CFG_PULSES_PER_FRAME] = TW'(pulses);
		setting[CFG_PULSES_DROPPED] = TW'(dropped);
	endfunction

	// Mostly short phases so that many frames pass; now and then a long or full-range one.
	function automatic logic [TW-1:0] random_ticks();
		case ($urandom_range(0, 15))
			0: return TW'($urandom());
			1, 2: return TW'($urandom_range(0, 40));
			default: return TW'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic void random_timing();
		int pulses, dropped;
		pulses = ($urandom_range(0, 3) == 0) ? $urandom_range(1, PULSE_COUNT_MAX) :
			$urandom_range(1, 6);
		dropped = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PULSE_COUNT_MAX) :
			$urandom_range(0, 4);
		set_timing(random_ticks(), random_ticks(), random_ticks(), random_ticks(),
			random_ticks(), pulses, dropped);
	endfunction

	task automatic load_settings();
		cfg_index_t idx;
		idx = idx.first();
		do begin
			cfg_write_en <= 1'b1;
			cfg_index <= idx;
			cfg_data <= setting[idx];
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_write_en <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic send_item(input logic eb, input logic sb);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		enable_button <= eb;
		select_button <= sb;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic run_items(input int count);
		repeat (count) begin
			if ($urandom_range(0, 2) == 0)
				eb_level = ~eb_level;
			if ($urandom_range(0, 2) == 0)
				sb_level = ~sb_level;
			send_item(eb_level, sb_level);
		end
		item_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 4);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Button edges on the reset settings: single presses, holds and both at once.
		foreach (press_seq[i])
			send_item(press_seq[i][1], press_seq[i][0]);
		item_valid <= 1'b0;

		// Every phase has zero length, so the block rests in the sync phase.
		wait_drained();
		set_timing('0, '0, '0, '0, '0, 1, 0);
		load_settings();
		run_items(6);

		// The second pulse width overflows the tick count and must saturate.
		wait_drained();
		set_timing(TW'(1), TW'(1), TICK_ALL_ONES, TW'(1), TW'(1), PULSE_COUNT_MAX, 0);
		load_settings();
		run_items(8);

		for (int p = 0; p < 16; p++) begin
			wait_drained();
			if (p == 3)
				set_timing(TICK_ALL_ONES, TICK_ALL_ONES, TICK_ALL_ONES, TICK_ALL_ONES,
					TICK_ALL_ONES, PULSE_COUNT_MAX, PULSE_COUNT_MAX);
			else
				random_timing();
			idle_on = (p < 12) && ($urandom_range(0, 3) != 0);
			load_settings();
			run_items(100);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("** sync_pulse_train_generator: PASSED **");
		else
			$display("** sync_pulse_train_generator: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** sync_pulse_train_generator: FAILED **");
		$finish;
	end

endmodule
